// ===== design/yuyv_lm_pkg.sv =====
// Shared types, constants and the output effect function of the YUYV line mirror.
package yuyv_lm_pkg;

   // Line store sizing default (macropixels per bank)
   localparam int MAX_LINE_MACROPIXELS = 1024;

   // Register widths and reset values
   localparam int LEN_W = 11;
   localparam logic [LEN_W-1:0] LINE_RESET = 11'd320;
   localparam int CSR_INDEX_W = 2;

   // Chroma value forced by monochrome
   localparam logic [7:0] CHROMA_MID = 8'h80;

   // Request kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_MACROPIXELS = 2'd0,
      CSR_MIRROR_ENABLE    = 2'd1,
      CSR_NEGATIVE_ENABLE  = 2'd2,
      CSR_MONO_ENABLE      = 2'd3
   } csr_index_type;

   // One macropixel, packed as stored: Y0 in the low byte, V in the high byte
   typedef struct packed {
      logic [7:0] chroma_red;
      logic [7:0] luma_second;
      logic [7:0] chroma_blue;
      logic [7:0] luma_first;
   } macropixel_type;

   // Per-request decision handed from the sequencer to the output stage
   typedef struct packed {
      logic emit;        // request yields a response
      logic from_store;  // response comes from the line store (mirrored)
      logic line_end;    // response closes a line
   } step_type;

   // Negative first, then monochrome
   function automatic macropixel_type apply_effects(macropixel_type px, logic negative,
                                                    logic mono);
      macropixel_type r;
      r = negative ? ~px : px;
      if (mono) begin
         r.chroma_blue = CHROMA_MID;
         r.chroma_red  = CHROMA_MID;
      end
      return r;
   endfunction

endpackage

// ===== design/yuyv_lm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module yuyv_lm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/yuyv_lm_ctrl.sv =====
// Line sequencer: fill position, bank select, pending count and store addressing.
module yuyv_lm_ctrl #(
   parameter int MAX_LINE_MACROPIXELS = yuyv_lm_pkg::MAX_LINE_MACROPIXELS
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         accept,
   input  logic                                         req_type,
   input  logic [yuyv_lm_pkg::LEN_W-1:0]                line_macropixels,
   input  logic                                         mirror_enable,
   output yuyv_lm_pkg::step_type                        step,
   output logic                                         rd_en,
   output logic [$clog2(2*MAX_LINE_MACROPIXELS)-1:0]    rd_addr,
   output logic                                         wr_en,
   output logic [$clog2(2*MAX_LINE_MACROPIXELS)-1:0]    wr_addr
);

   localparam int CW = $clog2(MAX_LINE_MACROPIXELS + 1);
   localparam int IW = $clog2(MAX_LINE_MACROPIXELS);
   localparam int AW = $clog2(2 * MAX_LINE_MACROPIXELS);

   logic [IW-1:0] fill_ff, fill_in;
   logic          bank_ff, bank_in;
   logic [CW-1:0] pending_ff, pending_in;

   logic [CW-1:0] len;
   logic [CW-1:0] pending_dec;
   logic [IW-1:0] drain_idx;
   logic          pending_nz;
   logic          ends;
   logic          drain;
   logic          is_flush;

   // Effective line length: zero acts as one, oversize clamps to the store size
   always_comb begin
      if (line_macropixels == '0) begin
         len = CW'(1);
      end else if (32'(line_macropixels) > 32'(MAX_LINE_MACROPIXELS)) begin
         len = CW'(MAX_LINE_MACROPIXELS);
      end else begin
         len = CW'(line_macropixels);
      end
   end

   assign is_flush    = (req_type == yuyv_lm_pkg::REQ_FLUSH);
   assign pending_nz  = (pending_ff != '0);
   assign pending_dec = pending_ff - CW'(1);
   assign drain_idx   = pending_dec[IW-1:0];
   assign ends        = (32'(fill_ff) + 32'd1) >= 32'(len);

   // Decision for this request
   always_comb begin
      step.from_store = is_flush || mirror_enable;
      step.emit       = step.from_store ? pending_nz : 1'b1;
      step.line_end   = step.from_store ? (pending_ff == CW'(1)) : ends;
   end

   assign drain = step.emit && step.from_store;

   // Store ports: read the other bank in reverse, write the filling bank
   assign rd_en   = accept && drain;
   assign rd_addr = (bank_ff ? AW'(0) : AW'(MAX_LINE_MACROPIXELS)) + AW'(drain_idx);
   assign wr_en   = accept && !is_flush;
   assign wr_addr = (bank_ff ? AW'(MAX_LINE_MACROPIXELS) : AW'(0)) + AW'(fill_ff);

   // Next state
   always_comb begin
      fill_in    = fill_ff;
      bank_in    = bank_ff;
      pending_in = pending_ff;
      if (accept) begin
         if (drain) begin
            pending_in = pending_dec;
         end
         if (!is_flush) begin
            if (ends) begin
               fill_in    = '0;
               bank_in    = ~bank_ff;
               pending_in = mirror_enable ? len : '0;
            end else begin
               fill_in = fill_ff + IW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         bank_ff    <= 1'b0;
         pending_ff <= '0;
      end else begin
         fill_ff    <= fill_in;
         bank_ff    <= bank_in;
         pending_ff <= pending_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_pending_range: assert property (@(posedge clock) disable iff (reset)
      32'(pending_ff) <= 32'(MAX_LINE_MACROPIXELS))
      else $error("pending count beyond line store size");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write hit the same store entry");

   a_bank_swap: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_flush && ends) |=> (bank_ff != $past(bank_ff)) && (fill_ff == '0))
      else $error("line end did not swap banks");
`endif

endmodule

// ===== design/yuyv_lm_out.sv =====
// Read-data stage and response register with effects applied on the way out.
module yuyv_lm_out (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  yuyv_lm_pkg::step_type      step,
   input  yuyv_lm_pkg::macropixel_type pass_px,
   input  yuyv_lm_pkg::macropixel_type store_px,
   input  logic                       negative_enable,
   input  logic                       mono_enable,
   output logic                       in_ready,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output yuyv_lm_pkg::macropixel_type rsp_px,
   output logic                       rsp_line_end
);

   // Stage 1: request waiting for store read data
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_from_store_ff;
   logic                        s1_line_end_ff;
   yuyv_lm_pkg::macropixel_type s1_px_ff;

   // Response register
   logic                        rsp_valid_ff, rsp_valid_in;
   yuyv_lm_pkg::macropixel_type rsp_px_ff;
   logic                        rsp_line_end_ff;

   logic                        s1_move;
   yuyv_lm_pkg::macropixel_type mirrored_px;
   yuyv_lm_pkg::macropixel_type sel_px;

   assign s1_move  = !rsp_valid_ff || rsp_ready;
   assign in_ready = !s1_valid_ff || s1_move;

   // Mirrored macropixel swaps its two luma samples
   always_comb begin
      mirrored_px             = store_px;
      mirrored_px.luma_first  = store_px.luma_second;
      mirrored_px.luma_second = store_px.luma_first;
      sel_px = s1_from_store_ff ? mirrored_px : s1_px_ff;
   end

   // Valid flags
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = step.emit;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = s1_move ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_from_store_ff <= step.from_store;
         s1_line_end_ff   <= step.line_end;
         s1_px_ff         <= pass_px;
      end
      if (s1_move && s1_valid_ff) begin
         rsp_px_ff       <= yuyv_lm_pkg::apply_effects(sel_px, negative_enable, mono_enable);
         rsp_line_end_ff <= s1_line_end_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_px       = rsp_px_ff;
   assign rsp_line_end = rsp_line_end_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |-> !accept)
      else $error("request accepted over a stalled read stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> s1_valid_ff && $stable(s1_line_end_ff))
      else $error("stalled read stage lost its request");

   a_fill_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_move) |=> rsp_valid_ff)
      else $error("read stage advanced without a response");
`endif

endmodule

// ===== design/yuyv_line_mirror_effects.sv =====
// Top level of the YUYV line mirror with negative and monochrome effects.
// YUYV line mirror with effects. One macropixel request is accepted every clock; a response
// passes through the line store read stage and then the response register, and full rate
// holds as long as rsp_ready stays high. With mirroring on, each pixel request is written into
// one bank of a two-bank line store (one write port) while the previous line is read back from
// the other bank in reverse order with Y0/Y1 swapped, so output runs one line late and the
// first line after enabling gives no responses; flush requests drain the remaining macropixels
// of that line. With mirroring off, pixels pass straight through. Negative inverts all bytes,
// then monochrome sets U and V to 0x80. The line store has no reset and needs no clearing pass;
// configuration must be written only while idle, which the block itself does not enforce.
module yuyv_line_mirror_effects #(
   parameter int MAX_LINE_MACROPIXELS = yuyv_lm_pkg::MAX_LINE_MACROPIXELS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [yuyv_lm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [yuyv_lm_pkg::LEN_W-1:0]          csr_data,
   // request
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_type,
   input  logic [7:0]                             req_luma_first,
   input  logic [7:0]                             req_chroma_blue,
   input  logic [7:0]                             req_luma_second,
   input  logic [7:0]                             req_chroma_red,
   // response
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [7:0]                             rsp_out_luma_first,
   output logic [7:0]                             rsp_out_chroma_blue,
   output logic [7:0]                             rsp_out_luma_second,
   output logic [7:0]                             rsp_out_chroma_red,
   output logic                                   rsp_line_end
);

   localparam int AW = $clog2(2 * MAX_LINE_MACROPIXELS);

   logic [yuyv_lm_pkg::LEN_W-1:0] line_ff;
   logic                          mirror_ff;
   logic                          negative_ff;
   logic                          mono_ff;

   logic                          accept;
   yuyv_lm_pkg::step_type         step;
   logic                          rd_en;
   logic                          wr_en;
   logic [AW-1:0]                 rd_addr;
   logic [AW-1:0]                 wr_addr;
   yuyv_lm_pkg::macropixel_type   req_px;
   yuyv_lm_pkg::macropixel_type   store_px;
   yuyv_lm_pkg::macropixel_type   rsp_px;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff     <= yuyv_lm_pkg::LINE_RESET;
         mirror_ff   <= 1'b0;
         negative_ff <= 1'b0;
         mono_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (yuyv_lm_pkg::csr_index_type'(csr_index))
            yuyv_lm_pkg::CSR_LINE_MACROPIXELS: line_ff     <= csr_data;
            yuyv_lm_pkg::CSR_MIRROR_ENABLE:    mirror_ff   <= csr_data[0];
            yuyv_lm_pkg::CSR_NEGATIVE_ENABLE:  negative_ff <= csr_data[0];
            yuyv_lm_pkg::CSR_MONO_ENABLE:      mono_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Request packing
   assign accept = req_valid && req_ready;

   always_comb begin
      req_px.luma_first  = req_luma_first;
      req_px.chroma_blue = req_chroma_blue;
      req_px.luma_second = req_luma_second;
      req_px.chroma_red  = req_chroma_red;
   end

   yuyv_lm_ctrl #(
      .MAX_LINE_MACROPIXELS(MAX_LINE_MACROPIXELS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_type         (req_type),
      .line_macropixels (line_ff),
      .mirror_enable    (mirror_ff),
      .step             (step),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr)
   );

   // Two-bank line store
   yuyv_lm_ram #(
      .WIDTH ($bits(yuyv_lm_pkg::macropixel_type)),
      .DEPTH (2 * MAX_LINE_MACROPIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_px),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (store_px)
   );

   yuyv_lm_out u_out (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .step            (step),
      .pass_px         (req_px),
      .store_px        (store_px),
      .negative_enable (negative_ff),
      .mono_enable     (mono_ff),
      .in_ready        (req_ready),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_px          (rsp_px),
      .rsp_line_end    (rsp_line_end)
   );

   assign rsp_out_luma_first  = rsp_px.luma_first;
   assign rsp_out_chroma_blue = rsp_px.chroma_blue;
   assign rsp_out_luma_second = rsp_px.luma_second;
   assign rsp_out_chroma_red  = rsp_px.chroma_red;

endmodule

// ===== sim/tb_yuyv_line_mirror_effects.sv =====
// Self-checking testbench for the YUYV line mirror with negative and monochrome effects.
module tb_yuyv_line_mirror_effects;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_MP         = yuyv_lm_pkg::MAX_LINE_MACROPIXELS;
   localparam int LW             = yuyv_lm_pkg::LEN_W;
   // margin after the last response so that silent requests clear the pipeline
   localparam int SETTLE_CYCLES  = 8;
   localparam int LIMIT_CYCLES   = 500000;
   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_REQUESTS = 100;
   localparam int HOLD_CYCLES    = 300;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
      logic       line_end;
   } out_pixel_type;

   typedef enum logic {ROW_CONFIG, ROW_REQUEST} row_kind_type;

   // one line of the directed table
   typedef struct {
      row_kind_type                 kind;
      logic [LW-1:0]                len;
      logic                         mirror;
      logic                         negative;
      logic                         mono;
      logic                         req_kind;
      yuyv_lm_pkg::macropixel_type  px;
      bit                           typed;      // expected outcome written in the row
      bit                           typed_has;
      out_pixel_type                typed_out;
   } stim_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   yuyv_lm_pkg::csr_index_type  csr_index = yuyv_lm_pkg::CSR_LINE_MACROPIXELS;
   logic [LW-1:0]               csr_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_type = yuyv_lm_pkg::REQ_PIXEL;
   logic [7:0]                  req_luma_first = 8'h00;
   logic [7:0]                  req_chroma_blue = 8'h00;
   logic [7:0]                  req_luma_second = 8'h00;
   logic [7:0]                  req_chroma_red = 8'h00;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [7:0]                  rsp_out_luma_first;
   logic [7:0]                  rsp_out_chroma_blue;
   logic [7:0]                  rsp_out_luma_second;
   logic [7:0]                  rsp_out_chroma_red;
   logic                        rsp_line_end;

   // predictor state: line store copy, write position, bank and drain count
   yuyv_lm_pkg::macropixel_type line_copy [2*MAX_MP];
   logic [LW-1:0]               cfg_len = yuyv_lm_pkg::LINE_RESET;
   logic                        cfg_mirror = 1'b0;
   logic                        cfg_negative = 1'b0;
   logic                        cfg_mono = 1'b0;
   int unsigned                 fill_pos = 0;
   int unsigned                 pending_left = 0;
   logic                        fill_half = 1'b0;

   out_pixel_type               awaited_pixels [$];
   int                          error_count = 0;
   int                          cycle_count = 0;
   int                          send_idle_pct = 0;
   int                          rsp_stall_pct = 0;
   bit                          pressure_request = 1'b0;

   yuyv_line_mirror_effects DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_luma_first      (req_luma_first),
      .req_chroma_blue     (req_chroma_blue),
      .req_luma_second     (req_luma_second),
      .req_chroma_red      (req_chroma_red),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_luma_first  (rsp_out_luma_first),
      .rsp_out_chroma_blue (rsp_out_chroma_blue),
      .rsp_out_luma_second (rsp_out_luma_second),
      .rsp_out_chroma_red  (rsp_out_chroma_red),
      .rsp_line_end        (rsp_line_end)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // negative first, then chroma forced to mid-scale
   function automatic out_pixel_type shade_pixel(logic [7:0] y0, logic [7:0] u,
                                                 logic [7:0] y1, logic [7:0] v, logic last);
      out_pixel_type r;
      if (cfg_negative) begin
         y0 = ~y0;
         u  = ~u;
         y1 = ~y1;
         v  = ~v;
      end
      if (cfg_mono) begin
         u = yuyv_lm_pkg::CHROMA_MID;
         v = yuyv_lm_pkg::CHROMA_MID;
      end
      r.luma_first  = y0;
      r.chroma_blue = u;
      r.luma_second = y1;
      r.chroma_red  = v;
      r.line_end    = last;
      return r;
   endfunction

   // next macropixel of the previous line, walked backward, lumas swapped
   task automatic read_back_line(output bit has, output out_pixel_type res);
      int unsigned                 idx;
      yuyv_lm_pkg::macropixel_type w;
      has = 1'b0;
      res = '0;
      if (pending_left != 0) begin
         idx = pending_left - 1;
         if (idx >= MAX_MP) idx = MAX_MP - 1;
         w = line_copy[(fill_half ? 0 : MAX_MP) + idx];
         pending_left--;
         res = shade_pixel(w.luma_second, w.chroma_blue, w.luma_first, w.chroma_red,
                           pending_left == 0);
         has = 1'b1;
      end
   endtask

   // expected response of one request; updates the predictor state
   task automatic predict_mirror_step(input logic kind, input yuyv_lm_pkg::macropixel_type px,
                                      output bit has, output out_pixel_type res);
      int unsigned span;
      int unsigned slot;
      bit          closes;
      span = 32'(cfg_len);
      if (span == 0) span = 1;
      if (span > MAX_MP) span = MAX_MP;
      if (kind == yuyv_lm_pkg::REQ_FLUSH) begin
         read_back_line(has, res);
      end else begin
         slot   = (fill_pos >= MAX_MP) ? MAX_MP - 1 : fill_pos;
         closes = (fill_pos + 1) >= span;
         if (cfg_mirror) begin
            read_back_line(has, res);
         end else begin
            has = 1'b1;
            res = shade_pixel(px.luma_first, px.chroma_blue, px.luma_second, px.chroma_red,
                              closes);
         end
         line_copy[(fill_half ? MAX_MP : 0) + slot] = px;
         if (closes) begin
            fill_pos     = 0;
            fill_half    = ~fill_half;
            pending_left = cfg_mirror ? span : 0;
         end else begin
            fill_pos++;
         end
      end
   endtask

   task automatic report_mismatch(string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_response(out_pixel_type got);
      out_pixel_type want;
      if (awaited_pixels.size() == 0) begin
         report_mismatch($sformatf("response %h with none outstanding", got));
      end else begin
         want = awaited_pixels.pop_front();
         if (got.luma_first !== want.luma_first)
            report_mismatch($sformatf("luma_first %h, expected %h",
                                      got.luma_first, want.luma_first));
         if (got.chroma_blue !== want.chroma_blue)
            report_mismatch($sformatf("chroma_blue %h, expected %h",
                                      got.chroma_blue, want.chroma_blue));
         if (got.luma_second !== want.luma_second)
            report_mismatch($sformatf("luma_second %h, expected %h",
                                      got.luma_second, want.luma_second));
         if (got.chroma_red !== want.chroma_red)
            report_mismatch($sformatf("chroma_red %h, expected %h",
                                      got.chroma_red, want.chroma_red));
         if (got.line_end !== want.line_end)
            report_mismatch($sformatf("line_end %b, expected %b",
                                      got.line_end, want.line_end));
      end
   endtask

   // response side: check, then pick ready for the next cycle
   initial begin : rsp_side
      int            hold_left;
      out_pixel_type got;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            got.luma_first  = rsp_out_luma_first;
            got.chroma_blue = rsp_out_chroma_blue;
            got.luma_second = rsp_out_luma_second;
            got.chroma_red  = rsp_out_chroma_red;
            got.line_end    = rsp_line_end;
            check_response(got);
         end
         // long hold-off so the block backs up into the request side
         if (pressure_request) begin
            hold_left        = HOLD_CYCLES;
            pressure_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // offer one request, then record what it should produce
   task automatic issue_request(input logic kind, input yuyv_lm_pkg::macropixel_type px,
                                input bit typed, input bit typed_has,
                                input out_pixel_type typed_out);
      bit            has;
      out_pixel_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_luma_first  <= px.luma_first;
      req_chroma_blue <= px.chroma_blue;
      req_luma_second <= px.luma_second;
      req_chroma_red  <= px.chroma_red;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_mirror_step(kind, px, has, res);
      if (typed) begin
         has = typed_has;
         res = typed_out;
      end
      if (has) awaited_pixels.push_back(res);
   endtask

   // drain everything outstanding, then let silent requests clear the pipeline
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (awaited_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four registers back to back
   task automatic program_registers(input logic [LW-1:0] len, input logic mir,
                                    input logic neg, input logic mono);
      yuyv_lm_pkg::csr_index_type reg_sel;
      logic [LW-1:0]              value;
      reg_sel = yuyv_lm_pkg::CSR_LINE_MACROPIXELS;
      repeat (reg_sel.num()) begin
         case (reg_sel)
            yuyv_lm_pkg::CSR_LINE_MACROPIXELS: value = len;
            yuyv_lm_pkg::CSR_MIRROR_ENABLE:    value = LW'(mir);
            yuyv_lm_pkg::CSR_NEGATIVE_ENABLE:  value = LW'(neg);
            default:                           value = LW'(mono);
         endcase
         csr_valid <= 1'b1;
         csr_index <= reg_sel;
         csr_data  <= value;
         do @(posedge clock); while (csr_ready !== 1'b1);
         case (reg_sel)
            yuyv_lm_pkg::CSR_LINE_MACROPIXELS: cfg_len      = value;
            yuyv_lm_pkg::CSR_MIRROR_ENABLE:    cfg_mirror   = value[0];
            yuyv_lm_pkg::CSR_NEGATIVE_ENABLE:  cfg_negative = value[0];
            default:                           cfg_mono     = value[0];
         endcase
         reg_sel = reg_sel.next();
      end
      csr_valid <= 1'b0;
   endtask

   function automatic stim_row_type config_row(logic [LW-1:0] len, logic mir, logic neg,
                                               logic mono);
      stim_row_type r;
      r          = '{kind: ROW_CONFIG, default: '0};
      r.len      = len;
      r.mirror   = mir;
      r.negative = neg;
      r.mono     = mono;
      return r;
   endfunction

   function automatic stim_row_type request_row(logic kind, logic [7:0] y0, logic [7:0] u,
                                                logic [7:0] y1, logic [7:0] v);
      stim_row_type r;
      r          = '{kind: ROW_REQUEST, default: '0};
      r.req_kind = kind;
      r.px       = '{chroma_red: v, luma_second: y1, chroma_blue: u, luma_first: y0};
      return r;
   endfunction

   function automatic stim_row_type checked_row(logic kind, logic [7:0] y0, logic [7:0] u,
                                                logic [7:0] y1, logic [7:0] v, bit has,
                                                logic [7:0] oy0, logic [7:0] ou,
                                                logic [7:0] oy1, logic [7:0] ov, logic last);
      stim_row_type r;
      r           = request_row(kind, y0, u, y1, v);
      r.typed     = 1'b1;
      r.typed_has = has;
      r.typed_out = '{luma_first: oy0, chroma_blue: ou, luma_second: oy1, chroma_red: ov,
                      line_end: last};
      return r;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      stim_row_type                rows [$];
      logic [LW-1:0]               p_len;
      logic                        p_mir;
      logic                        p_neg;
      logic                        p_mono;
      logic                        kind;
      yuyv_lm_pkg::macropixel_type px;
      int                          flush_pct;

      // passthrough from reset: extremes, flush with nothing pending
      rows.push_back(checked_row(yuyv_lm_pkg::REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
                                 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
      rows.push_back(checked_row(yuyv_lm_pkg::REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      rows.push_back(checked_row(yuyv_lm_pkg::REQ_FLUSH, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 1'b0,
                                 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
      // zero length acts as one: every pixel closes a line
      rows.push_back(config_row(11'd0, 1'b0, 1'b0, 1'b0));
      rows.push_back(checked_row(yuyv_lm_pkg::REQ_PIXEL, 8'h12, 8'h34, 8'h56, 8'h78, 1'b1,
                                 8'h12, 8'h34, 8'h56, 8'h78, 1'b1));
      // negative, negative plus mono, mono alone
      rows.push_back(config_row(11'd1, 1'b0, 1'b1, 1'b0));
      rows.push_back(checked_row(yuyv_lm_pkg::REQ_PIXEL, 8'h00, 8'hFF, 8'h0F, 8'hF0, 1'b1,
                                 8'hFF, 8'h00, 8'hF0, 8'h0F, 1'b1));
      rows.push_back(config_row(11'd1, 1'b0, 1'b1, 1'b1));
      rows.push_back(checked_row(yuyv_lm_pkg::REQ_PIXEL, 8'h12, 8'h34, 8'h56, 8'h78, 1'b1,
                                 8'hED, 8'h80, 8'hA9, 8'h80, 1'b1));
      rows.push_back(config_row(11'd1, 1'b0, 1'b0, 1'b1));
      rows.push_back(checked_row(yuyv_lm_pkg::REQ_PIXEL, 8'hAA, 8'h55, 8'hCC, 8'h33, 1'b1,
                                 8'hAA, 8'h80, 8'hCC, 8'h80, 1'b1));
      // mirror: silent first line, then reversed output and flushes
      rows.push_back(config_row(11'd2, 1'b1, 1'b0, 1'b0));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_PIXEL, 8'h01, 8'h02, 8'h03, 8'h04));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_PIXEL, 8'h11, 8'h12, 8'h13, 8'h14));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_PIXEL, 8'h21, 8'h22, 8'h23, 8'h24));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_PIXEL, 8'h31, 8'h32, 8'h33, 8'h34));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_FLUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      rows.push_back(checked_row(yuyv_lm_pkg::REQ_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
      // length above the store size, then cut short in the middle of the line
      rows.push_back(config_row(11'd2047, 1'b1, 1'b0, 1'b0));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_PIXEL, 8'h61, 8'h62, 8'h63, 8'h64));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_PIXEL, 8'h71, 8'h72, 8'h73, 8'h74));
      rows.push_back(config_row(11'd2, 1'b1, 1'b1, 1'b0));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_PIXEL, 8'h81, 8'h82, 8'h83, 8'h84));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_PIXEL, 8'h91, 8'h92, 8'h93, 8'h94));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_PIXEL, 8'hA1, 8'hA2, 8'hA3, 8'hA4));
      // flush still drains once mirroring is off; a closing line leaves nothing pending
      rows.push_back(config_row(11'd2, 1'b0, 1'b0, 1'b0));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_PIXEL, 8'hB1, 8'hB2, 8'hB3, 8'hB4));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00));
      rows.push_back(request_row(yuyv_lm_pkg::REQ_PIXEL, 8'hC1, 8'hC2, 8'hC3, 8'hC4));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CONFIG) begin
            wait_until_idle();
            program_registers(rows[i].len, rows[i].mirror, rows[i].negative, rows[i].mono);
         end else begin
            issue_request(rows[i].req_kind, rows[i].px, rows[i].typed, rows[i].typed_has,
                          rows[i].typed_out);
         end
      end

      // random phases, each with its own register setting and idling mix
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: {p_len, p_mir, p_neg, p_mono} = {11'd4,    3'b100};
            1: {p_len, p_mir, p_neg, p_mono} = {11'd1,    3'b010};
            2: {p_len, p_mir, p_neg, p_mono} = {11'd7,    3'b111};
            3: {p_len, p_mir, p_neg, p_mono} = {11'd1024, 3'b100};
            4: {p_len, p_mir, p_neg, p_mono} = {11'd5,    3'b101};
            5: {p_len, p_mir, p_neg, p_mono} = {11'd0,    3'b110};
            6: {p_len, p_mir, p_neg, p_mono} = {11'd16,   3'b011};
            7: {p_len, p_mir, p_neg, p_mono} = {11'd9,    3'b100};
            default: begin
               p_len  = ($urandom_range(7) == 0) ? LW'($urandom_range(64, 1))
                                                 : LW'($urandom_range(12, 1));
               p_mir  = $urandom_range(3) != 0;
               p_neg  = 1'($urandom_range(1));
               p_mono = 1'($urandom_range(1));
            end
         endcase
         wait_until_idle();
         program_registers(p_len, p_mir, p_neg, p_mono);
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 72; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 72; end
            default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
         endcase
         if (phase == 7) pressure_request = 1'b1;
         flush_pct = cfg_mirror ? 15 : 8;
         repeat (PHASE_REQUESTS) begin
            kind           = ($urandom_range(99) < flush_pct) ? yuyv_lm_pkg::REQ_FLUSH
                                                              : yuyv_lm_pkg::REQ_PIXEL;
            px.luma_first  = pick_byte();
            px.chroma_blue = pick_byte();
            px.luma_second = pick_byte();
            px.chroma_red  = pick_byte();
            issue_request(kind, px, 1'b0, 1'b0, '0);
         end
      end

      wait_until_idle();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
